// ----- hw/rtl/tro_pkg.sv -----
package tro_pkg;

	// default coordinate width
	localparam int COORD_WIDTH_DEF = 32;

	// entries in the front-to-back queue
	localparam int QUEUE_DEPTH_DEF = 2;

	// partial products per rectangle pair: three areas, four half products each
	localparam int NUM_PP = 12;
	localparam int STEP_W = 4;

	// area slots in the front: subject, clip, bounding box
	localparam int NUM_AREAS = 3;
	localparam logic [1:0] AREA_S = 2'd0;
	localparam logic [1:0] AREA_C = 2'd1;
	localparam logic [1:0] AREA_U = 2'd2;

	// coordinate slots in one queue entry: path 0 rect, path 1 rect, meet rect
	localparam int NUM_COORDS = 12;
	localparam int C_P0 = 0;
	localparam int C_P1 = 4;
	localparam int C_MEET = 8;
	localparam int OFS_L = 0;
	localparam int OFS_T = 1;
	localparam int OFS_R = 2;
	localparam int OFS_B = 3;

	// what the back emits for one pair
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_ONE,
		KIND_TWO
	} kind_t;

	// vertex order of one emitted path
	typedef enum logic [2:0] {
		SHP_RECT,
		SHP_FLUSH_H,
		SHP_FLUSH_V,
		SHP_CUT_RB,
		SHP_CUT_RT,
		SHP_CUT_LT,
		SHP_CUT_LB
	} shape_t;

	// front sequencer states
	typedef enum logic {
		FR_IDLE,
		FR_MUL
	} front_state_t;

	// control part of one queue entry
	typedef struct packed {
		kind_t  kind;
		shape_t shape0;
		shape_t shape1;
	} ent_ctrl_t;

endpackage

// ----- hw/rtl/two_rectangle_xor_outline.sv -----
// a pair goes through the front steps, the queue and the back's entry and result registers
// 12 partial products per pair go through one shared multiplier before the next pair is taken
// the back emits 1 to 12 vertices per pair, one per cycle, while the front works on the next pair
// results cannot be held off; each vertex is on the ports for exactly one cycle
// arst_n low clears the front sequencer, the queue and the emitter; no pair survives reset
module two_rectangle_xor_outline #(
	parameter int COORD_WIDTH = tro_pkg::COORD_WIDTH_DEF,
	parameter int QUEUE_DEPTH = tro_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] subj_left,
	input  logic signed [COORD_WIDTH-1:0] subj_top,
	input  logic signed [COORD_WIDTH-1:0] subj_right,
	input  logic signed [COORD_WIDTH-1:0] subj_bottom,
	input  logic signed [COORD_WIDTH-1:0] clip_left,
	input  logic signed [COORD_WIDTH-1:0] clip_top,
	input  logic signed [COORD_WIDTH-1:0] clip_right,
	input  logic signed [COORD_WIDTH-1:0] clip_bottom,
	output logic                          result_valid,
	output logic                          handled,
	output logic                          path_index,
	output logic signed [COORD_WIDTH-1:0] vertex_x,
	output logic signed [COORD_WIDTH-1:0] vertex_y,
	output logic                          path_end,
	output logic                          last
);

	localparam int CTRL_W = $bits(tro_pkg::ent_ctrl_t);
	localparam int XY_W = tro_pkg::NUM_COORDS * COORD_WIDTH;
	localparam int Q_W = CTRL_W + XY_W;

	logic push, full, pop, empty;
	tro_pkg::ent_ctrl_t push_ctrl, pop_ctrl;
	logic [tro_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0] push_coords, pop_coords;
	logic [Q_W-1:0] q_in, q_out;

	// classification front
	tro_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.subj_left  (subj_left),
		.subj_top   (subj_top),
		.subj_right (subj_right),
		.subj_bottom(subj_bottom),
		.clip_left  (clip_left),
		.clip_top   (clip_top),
		.clip_right (clip_right),
		.clip_bottom(clip_bottom),
		.push       (push),
		.push_ctrl  (push_ctrl),
		.push_coords(push_coords),
		.full       (full)
	);

	// queue between front and back
	assign q_in = {push_ctrl, push_coords};

	tro_queue #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(q_in),
		.full     (full),
		.pop      (pop),
		.pop_data (q_out),
		.empty    (empty)
	);

	assign pop_ctrl = tro_pkg::ent_ctrl_t'(q_out[Q_W-1:XY_W]);
	assign pop_coords = q_out[XY_W-1:0];

	// vertex emitter
	tro_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.pop         (pop),
		.pop_ctrl    (pop_ctrl),
		.pop_coords  (pop_coords),
		.result_valid(result_valid),
		.handled     (handled),
		.path_index  (path_index),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.path_end    (path_end),
		.last        (last)
	);

endmodule

// ----- hw/rtl/tro_front.sv -----
module tro_front #(
	parameter int COORD_WIDTH = tro_pkg::COORD_WIDTH_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                start,
	output logic                                                busy,
	input  logic signed [COORD_WIDTH-1:0]                       subj_left,
	input  logic signed [COORD_WIDTH-1:0]                       subj_top,
	input  logic signed [COORD_WIDTH-1:0]                       subj_right,
	input  logic signed [COORD_WIDTH-1:0]                       subj_bottom,
	input  logic signed [COORD_WIDTH-1:0]                       clip_left,
	input  logic signed [COORD_WIDTH-1:0]                       clip_top,
	input  logic signed [COORD_WIDTH-1:0]                       clip_right,
	input  logic signed [COORD_WIDTH-1:0]                       clip_bottom,
	output logic                                                push,
	output tro_pkg::ent_ctrl_t                                  push_ctrl,
	output logic [tro_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0]     push_coords,
	input  logic                                                full
);

	localparam int W = COORD_WIDTH;
	localparam int HALF = (W + 1) / 2;
	localparam int EXT_W = 2 * HALF;
	localparam int ACC_W = 4 * HALF + 2;

	// exactly two sides shared with the meet, and not two opposite ones
	function automatic logic cut_ok(input logic tl, input logic tt, input logic tr,
		input logic tb);
		logic [2:0] cnt;
		cnt = 3'(tl) + 3'(tt) + 3'(tr) + 3'(tb);
		return (cnt == 3'd2) && !(tl && tr) && !(tt && tb);
	endfunction

	function automatic tro_pkg::shape_t cut_shape(input logic tl, input logic tt,
		input logic tr, input logic tb);
		tro_pkg::shape_t shp;
		if (tr && tb) begin
			shp = tro_pkg::SHP_CUT_RB;
		end else if (tr && tt) begin
			shp = tro_pkg::SHP_CUT_RT;
		end else if (tl && tt) begin
			shp = tro_pkg::SHP_CUT_LT;
		end else begin
			shp = tro_pkg::SHP_CUT_LB;
		end
		return shp;
	endfunction

	tro_pkg::front_state_t state_q, state_d;
	logic [tro_pkg::STEP_W-1:0] step_q, step_d;

	logic signed [W-1:0] sl_q, st_q, sr_q, sb_q, cl_q, ct_q, cr_q, cb_q;
	logic [EXT_W-1:0] ext_w_q [tro_pkg::NUM_AREAS];
	logic [EXT_W-1:0] ext_h_q [tro_pkg::NUM_AREAS];
	logic [EXT_W-1:0] pp_q;
	logic [1:0] pp_sub_q;
	logic pp_neg_q;
	logic [ACC_W-1:0] acc_q;

	logic accept, last_step;

	// extents of subject, clip and bounding box at the input
	logic signed [W-1:0] al [tro_pkg::NUM_AREAS];
	logic signed [W-1:0] at [tro_pkg::NUM_AREAS];
	logic signed [W-1:0] ar [tro_pkg::NUM_AREAS];
	logic signed [W-1:0] ab [tro_pkg::NUM_AREAS];
	logic [W-1:0] dw [tro_pkg::NUM_AREAS];
	logic [W-1:0] dh [tro_pkg::NUM_AREAS];
	logic [EXT_W-1:0] in_ext_w [tro_pkg::NUM_AREAS];
	logic [EXT_W-1:0] in_ext_h [tro_pkg::NUM_AREAS];

	always_comb begin
		al[tro_pkg::AREA_S] = subj_left;
		at[tro_pkg::AREA_S] = subj_top;
		ar[tro_pkg::AREA_S] = subj_right;
		ab[tro_pkg::AREA_S] = subj_bottom;
		al[tro_pkg::AREA_C] = clip_left;
		at[tro_pkg::AREA_C] = clip_top;
		ar[tro_pkg::AREA_C] = clip_right;
		ab[tro_pkg::AREA_C] = clip_bottom;
		al[tro_pkg::AREA_U] = (subj_left < clip_left) ? subj_left : clip_left;
		at[tro_pkg::AREA_U] = (subj_top < clip_top) ? subj_top : clip_top;
		ar[tro_pkg::AREA_U] = (subj_right > clip_right) ? subj_right : clip_right;
		ab[tro_pkg::AREA_U] = (subj_bottom > clip_bottom) ? subj_bottom : clip_bottom;
		for (int k = 0; k < tro_pkg::NUM_AREAS; k++) begin
			dw[k] = ar[k] - al[k];
			dh[k] = ab[k] - at[k];
			if (ar[k] > al[k] && ab[k] > at[k]) begin
				in_ext_w[k] = EXT_W'(dw[k]);
				in_ext_h[k] = EXT_W'(dh[k]);
			end else begin
				in_ext_w[k] = '0;
				in_ext_h[k] = '0;
			end
		end
	end

	// shared multiplier: one half-width partial product per step
	logic [1:0] area_idx, sub;
	logic [HALF-1:0] mul_a, mul_b;
	logic [EXT_W-1:0] product;

	assign area_idx = step_q[tro_pkg::STEP_W-1:2];
	assign sub = step_q[1:0];
	assign mul_a = sub[1] ? ext_w_q[area_idx][EXT_W-1:HALF] : ext_w_q[area_idx][HALF-1:0];
	assign mul_b = sub[0] ? ext_h_q[area_idx][EXT_W-1:HALF] : ext_h_q[area_idx][HALF-1:0];
	assign product = EXT_W'(mul_a) * EXT_W'(mul_b);

	// accumulate area(s) + area(c) - area(bounding box)
	logic [ACC_W-1:0] term, term_sh, acc_sum;

	always_comb begin
		term = ACC_W'(pp_q);
		if (pp_sub_q[1] && pp_sub_q[0]) begin
			term_sh = term << (2 * HALF);
		end else if (pp_sub_q[1] ^ pp_sub_q[0]) begin
			term_sh = term << HALF;
		end else begin
			term_sh = term;
		end
		acc_sum = pp_neg_q ? (acc_q - term_sh) : (acc_q + term_sh);
	end

	// sequencer
	assign last_step = (state_q == tro_pkg::FR_MUL) &&
		(step_q == tro_pkg::STEP_W'(tro_pkg::NUM_PP));
	assign push = last_step && !full;
	assign busy = !((state_q == tro_pkg::FR_IDLE) || push);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		case (state_q)
			tro_pkg::FR_IDLE: begin
				if (accept) begin
					state_d = tro_pkg::FR_MUL;
					step_d = '0;
				end
			end
			tro_pkg::FR_MUL: begin
				if (push) begin
					state_d = accept ? tro_pkg::FR_MUL : tro_pkg::FR_IDLE;
					step_d = '0;
				end else if (!last_step) begin
					step_d = step_q + 1'b1;
				end
			end
			default: begin
				state_d = tro_pkg::FR_IDLE;
				step_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tro_pkg::FR_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
		end
	end

	// operand capture, partial products and accumulator
	always_ff @(posedge clk) begin
		if (accept) begin
			sl_q <= subj_left;
			st_q <= subj_top;
			sr_q <= subj_right;
			sb_q <= subj_bottom;
			cl_q <= clip_left;
			ct_q <= clip_top;
			cr_q <= clip_right;
			cb_q <= clip_bottom;
			ext_w_q <= in_ext_w;
			ext_h_q <= in_ext_h;
			acc_q <= '0;
		end else if (state_q == tro_pkg::FR_MUL && !last_step) begin
			pp_q <= product;
			pp_sub_q <= sub;
			pp_neg_q <= (area_idx == tro_pkg::AREA_U);
			if (step_q != '0) begin
				acc_q <= acc_sum;
			end
		end
	end

	// classification on the last step
	logic signed [W-1:0] ml, mt, mr, mb, ul, ut, ur, ub;
	logic strict, union_ok, vert_touch, horz_touch, flush_h, flush_v, share;
	logic s_ok, c_ok;
	tro_pkg::ent_ctrl_t ctrl;

	always_comb begin
		ml = (sl_q > cl_q) ? sl_q : cl_q;
		mt = (st_q > ct_q) ? st_q : ct_q;
		mr = (sr_q < cr_q) ? sr_q : cr_q;
		mb = (sb_q < cb_q) ? sb_q : cb_q;
		ul = (sl_q < cl_q) ? sl_q : cl_q;
		ut = (st_q < ct_q) ? st_q : ct_q;
		ur = (sr_q > cr_q) ? sr_q : cr_q;
		ub = (sb_q > cb_q) ? sb_q : cb_q;
		strict = (ml < mr) && (mt < mb);
		union_ok = (acc_sum == '0);
		vert_touch = (sr_q == cl_q) || (cr_q == sl_q);
		horz_touch = (sb_q == ct_q) || (cb_q == st_q);
		flush_h = (st_q == ct_q) && (sb_q == cb_q) && vert_touch;
		flush_v = (sl_q == cl_q) && (sr_q == cr_q) && horz_touch;
		share = (vert_touch && (mt < mb)) || (horz_touch && (ml < mr));
		s_ok = cut_ok(ml == sl_q, mt == st_q, mr == sr_q, mb == sb_q);
		c_ok = cut_ok(ml == cl_q, mt == ct_q, mr == cr_q, mb == cb_q);

		ctrl.kind = tro_pkg::KIND_NONE;
		ctrl.shape0 = tro_pkg::SHP_RECT;
		ctrl.shape1 = tro_pkg::SHP_RECT;
		if (!strict) begin
			if (union_ok) begin
				ctrl.kind = tro_pkg::KIND_ONE;
				if (flush_h) begin
					ctrl.shape0 = tro_pkg::SHP_FLUSH_H;
				end else if (flush_v) begin
					ctrl.shape0 = tro_pkg::SHP_FLUSH_V;
				end
			end else if (!share) begin
				ctrl.kind = tro_pkg::KIND_TWO;
			end
		end else if (s_ok && c_ok) begin
			ctrl.kind = tro_pkg::KIND_TWO;
			ctrl.shape0 = cut_shape(ml == sl_q, mt == st_q, mr == sr_q, mb == sb_q);
			ctrl.shape1 = cut_shape(ml == cl_q, mt == ct_q, mr == cr_q, mb == cb_q);
		end

		// path 0 is the bounding box for a single path, else the subject
		if (ctrl.kind == tro_pkg::KIND_ONE) begin
			push_coords[tro_pkg::C_P0 + tro_pkg::OFS_L] = ul;
			push_coords[tro_pkg::C_P0 + tro_pkg::OFS_T] = ut;
			push_coords[tro_pkg::C_P0 + tro_pkg::OFS_R] = ur;
			push_coords[tro_pkg::C_P0 + tro_pkg::OFS_B] = ub;
		end else begin
			push_coords[tro_pkg::C_P0 + tro_pkg::OFS_L] = sl_q;
			push_coords[tro_pkg::C_P0 + tro_pkg::OFS_T] = st_q;
			push_coords[tro_pkg::C_P0 + tro_pkg::OFS_R] = sr_q;
			push_coords[tro_pkg::C_P0 + tro_pkg::OFS_B] = sb_q;
		end
		push_coords[tro_pkg::C_P1 + tro_pkg::OFS_L] = cl_q;
		push_coords[tro_pkg::C_P1 + tro_pkg::OFS_T] = ct_q;
		push_coords[tro_pkg::C_P1 + tro_pkg::OFS_R] = cr_q;
		push_coords[tro_pkg::C_P1 + tro_pkg::OFS_B] = cb_q;
		push_coords[tro_pkg::C_MEET + tro_pkg::OFS_L] = ml;
		push_coords[tro_pkg::C_MEET + tro_pkg::OFS_T] = mt;
		push_coords[tro_pkg::C_MEET + tro_pkg::OFS_R] = mr;
		push_coords[tro_pkg::C_MEET + tro_pkg::OFS_B] = mb;
	end

	assign push_ctrl = ctrl;

endmodule

// ----- hw/rtl/tro_queue.sv -----
module tro_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tro_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hw/rtl/tro_back.sv -----
module tro_back #(
	parameter int COORD_WIDTH = tro_pkg::COORD_WIDTH_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            empty,
	output logic                                            pop,
	input  tro_pkg::ent_ctrl_t                              pop_ctrl,
	input  logic [tro_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0] pop_coords,
	output logic                                            result_valid,
	output logic                                            handled,
	output logic                                            path_index,
	output logic signed [COORD_WIDTH-1:0]                   vertex_x,
	output logic signed [COORD_WIDTH-1:0]                   vertex_y,
	output logic                                            path_end,
	output logic                                            last
);

	localparam int W = COORD_WIDTH;

	// coordinate picks: own rect low/high side, meet low/high side
	localparam logic [1:0] PLO = 2'd0;
	localparam logic [1:0] PHI = 2'd1;
	localparam logic [1:0] ILO = 2'd2;
	localparam logic [1:0] IHI = 2'd3;

	localparam logic [2:0] RECT_LAST = 3'd3;
	localparam logic [2:0] SIX_LAST = 3'd5;

	// vertex order tables, vertex 0 in the rightmost slot
	function automatic logic [3:0] pick(input tro_pkg::shape_t shp, input logic [2:0] j);
		logic [5:0][1:0] xt, yt;
		case (shp)
			tro_pkg::SHP_RECT: begin
				xt = {PLO, PLO, PHI, PLO, PLO, PHI};
				yt = {PLO, PLO, PLO, PLO, PHI, PHI};
			end
			tro_pkg::SHP_FLUSH_H: begin
				xt = {PLO, PLO, ILO, PHI, PHI, ILO};
				yt = {PLO, PHI, PHI, PHI, PLO, PLO};
			end
			tro_pkg::SHP_FLUSH_V: begin
				xt = {PHI, PHI, PLO, PLO, PLO, PHI};
				yt = {ILO, PLO, PLO, ILO, PHI, PHI};
			end
			tro_pkg::SHP_CUT_RB: begin
				xt = {PHI, PLO, PLO, ILO, ILO, PHI};
				yt = {PLO, PLO, PHI, PHI, ILO, ILO};
			end
			tro_pkg::SHP_CUT_RT: begin
				xt = {ILO, PLO, PLO, PHI, PHI, ILO};
				yt = {PLO, PLO, PHI, PHI, IHI, IHI};
			end
			tro_pkg::SHP_CUT_LT: begin
				xt = {PHI, IHI, IHI, PLO, PLO, PHI};
				yt = {PLO, PLO, IHI, IHI, PHI, PHI};
			end
			tro_pkg::SHP_CUT_LB: begin
				xt = {PHI, PLO, PLO, IHI, IHI, PHI};
				yt = {PLO, PLO, ILO, ILO, PHI, PHI};
			end
			default: begin
				xt = '0;
				yt = '0;
			end
		endcase
		return {xt[j], yt[j]};
	endfunction

	tro_pkg::ent_ctrl_t cur_ctrl_q;
	logic [tro_pkg::NUM_COORDS-1:0][W-1:0] cur_xy_q;
	logic active_q, path_q;
	logic [2:0] vert_q;

	tro_pkg::shape_t shp;
	logic is_none, is_end, is_last;
	logic [1:0] xsel, ysel;
	logic [W-1:0] p_l, p_t, p_r, p_b, vx, vy;

	// current vertex
	always_comb begin
		shp = path_q ? cur_ctrl_q.shape1 : cur_ctrl_q.shape0;
		is_none = (cur_ctrl_q.kind == tro_pkg::KIND_NONE);
		is_end = (vert_q == ((shp == tro_pkg::SHP_RECT) ? RECT_LAST : SIX_LAST));
		is_last = is_none || (is_end && ((cur_ctrl_q.kind != tro_pkg::KIND_TWO) || path_q));
		{xsel, ysel} = pick(shp, vert_q);
		p_l = path_q ? cur_xy_q[tro_pkg::C_P1 + tro_pkg::OFS_L]
			: cur_xy_q[tro_pkg::C_P0 + tro_pkg::OFS_L];
		p_t = path_q ? cur_xy_q[tro_pkg::C_P1 + tro_pkg::OFS_T]
			: cur_xy_q[tro_pkg::C_P0 + tro_pkg::OFS_T];
		p_r = path_q ? cur_xy_q[tro_pkg::C_P1 + tro_pkg::OFS_R]
			: cur_xy_q[tro_pkg::C_P0 + tro_pkg::OFS_R];
		p_b = path_q ? cur_xy_q[tro_pkg::C_P1 + tro_pkg::OFS_B]
			: cur_xy_q[tro_pkg::C_P0 + tro_pkg::OFS_B];
		case (xsel)
			PLO: vx = p_l;
			PHI: vx = p_r;
			ILO: vx = cur_xy_q[tro_pkg::C_MEET + tro_pkg::OFS_L];
			IHI: vx = cur_xy_q[tro_pkg::C_MEET + tro_pkg::OFS_R];
			default: vx = p_l;
		endcase
		case (ysel)
			PLO: vy = p_t;
			PHI: vy = p_b;
			ILO: vy = cur_xy_q[tro_pkg::C_MEET + tro_pkg::OFS_T];
			IHI: vy = cur_xy_q[tro_pkg::C_MEET + tro_pkg::OFS_B];
			default: vy = p_t;
		endcase
	end

	// take the next entry as soon as the current one finishes
	assign pop = !empty && (!active_q || is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			path_q <= 1'b0;
			vert_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				path_q <= 1'b0;
				vert_q <= '0;
			end else if (active_q && is_last) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				if (is_end) begin
					path_q <= 1'b1;
					vert_q <= '0;
				end else begin
					vert_q <= vert_q + 1'b1;
				end
			end
		end
	end

	// entry and result registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_ctrl_q <= pop_ctrl;
			cur_xy_q <= pop_coords;
		end
		handled <= !is_none;
		path_index <= !is_none && path_q;
		vertex_x <= is_none ? '0 : $signed(vx);
		vertex_y <= is_none ? '0 : $signed(vy);
		path_end <= !is_none && is_end;
		last <= is_last;
	end

endmodule

// ----- hw/rtl/tro_checker.sv -----
module tro_checker #(
	parameter int COORD_WIDTH = tro_pkg::COORD_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          result_valid,
	input logic                          handled,
	input logic                          path_index,
	input logic signed [COORD_WIDTH-1:0] vertex_x,
	input logic signed [COORD_WIDTH-1:0] vertex_y,
	input logic                          path_end,
	input logic                          last
);

	// a taken transaction keeps the front busy in the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("front not busy after a taken transaction");

	// a fallback answer is a single all-zero item
	a_fallback_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !handled) |-> (last && !path_end && !path_index &&
		vertex_x == '0 && vertex_y == '0))
		else $error("fallback item is not a lone zero item");

	// the final vertex of an answer closes its path
	a_last_closes_path: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && handled && last) |-> path_end)
		else $error("last vertex does not close a path");

	// vertices of one answer come in consecutive cycles
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |=> result_valid)
		else $error("gap inside one answer");

	// closing path 0 early means path 1 follows
	a_second_path: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && path_end && !last && !path_index) |=> (result_valid && path_index))
		else $error("second path does not follow");

endmodule

bind two_rectangle_xor_outline tro_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_tro_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.result_valid(result_valid),
	.handled     (handled),
	.path_index  (path_index),
	.vertex_x    (vertex_x),
	.vertex_y    (vertex_y),
	.path_end    (path_end),
	.last        (last)
);

// ----- sim/two_rectangle_xor_outline_test.sv -----
module two_rectangle_xor_outline_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = tro_pkg::COORD_WIDTH_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_PAIRS = 250;

	typedef logic signed [CW-1:0] coord_t;
	localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};

	// one rectangle pair as driven on the ports
	typedef struct packed {
		coord_t sl, st, sr, sb;
		coord_t cl, ct, cr, cb;
	} pair_t;

	// one emitted vertex as seen on the result ports
	typedef struct packed {
		logic   handled;
		logic   path;
		coord_t x;
		coord_t y;
		logic   path_end;
		logic   last;
	} vertex_t;

	// rectangle edges widened for exact comparisons
	typedef struct packed {
		longint l, t, r, b;
	} box_t;

	typedef longint path6_t [6];
	typedef coord_t axis4_t [4];
	typedef logic [129:0] area_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	pair_t  drv = '0;
	logic   busy;
	logic   result_valid;
	logic   handled;
	logic   path_index;
	coord_t vertex_x;
	coord_t vertex_y;
	logic   path_end;
	logic   last;

	pair_t   pair_q[$];
	vertex_t expected_vertices[$];
	vertex_t outline_q[$];

	int mismatches = 0;
	int pairs_taken = 0;
	int vertices_seen = 0;
	int refusals = 0;
	int two_path_outlines = 0;
	int stall_cycles = 0;
	int gap_left = 0;
	int steady_left = 0;
	bit taken;

	two_rectangle_xor_outline uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.subj_left    (drv.sl),
		.subj_top     (drv.st),
		.subj_right   (drv.sr),
		.subj_bottom  (drv.sb),
		.clip_left    (drv.cl),
		.clip_top     (drv.ct),
		.clip_right   (drv.cr),
		.clip_bottom  (drv.cb),
		.result_valid (result_valid),
		.handled      (handled),
		.path_index   (path_index),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.path_end     (path_end),
		.last         (last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// geometry helpers for the outline predictor
	function automatic longint lmax(longint a, longint b);
		return (a > b) ? a : b;
	endfunction

	function automatic longint lmin(longint a, longint b);
		return (a < b) ? a : b;
	endfunction

	function automatic box_t meet_of(box_t a, box_t b);
		box_t m;
		m.l = lmax(a.l, b.l);
		m.t = lmax(a.t, b.t);
		m.r = lmin(a.r, b.r);
		m.b = lmin(a.b, b.b);
		return m;
	endfunction

	function automatic bit is_proper(box_t q);
		return !(q.l >= q.r || q.t >= q.b);
	endfunction

	// exact area, zero for empty or inverted boxes
	function automatic area_t box_area(box_t q);
		logic [63:0] w, h;
		if (!is_proper(q)) return '0;
		w = q.r - q.l;
		h = q.b - q.t;
		return area_t'(w) * area_t'(h);
	endfunction

	function automatic bit shares_side(box_t a, box_t b);
		bit vert, horz;
		vert = (a.r == b.l || b.r == a.l) && lmax(a.t, b.t) < lmin(a.b, b.b);
		horz = (a.b == b.t || b.b == a.t) && lmax(a.l, b.l) < lmin(a.r, b.r);
		return vert || horz;
	endfunction

	// s minus c as a 6-vertex path when the overlap takes exactly one corner
	function automatic bit corner_cut(box_t s, box_t c, output path6_t xs, output path6_t ys);
		box_t ov;
		bit tl, tt, tr, tb;
		xs = '{default: 0};
		ys = '{default: 0};
		ov = meet_of(s, c);
		if (!is_proper(ov)) return 1'b0;
		tl = ov.l == s.l;
		tt = ov.t == s.t;
		tr = ov.r == s.r;
		tb = ov.b == s.b;
		if ($countones({tl, tt, tr, tb}) != 2) return 1'b0;
		if (tr && tb) begin
			xs = '{s.r, ov.l, ov.l, s.l, s.l, s.r};
			ys = '{ov.t, ov.t, s.b, s.b, s.t, s.t};
			return 1'b1;
		end
		if (tr && tt) begin
			xs = '{ov.l, s.r, s.r, s.l, s.l, ov.l};
			ys = '{ov.b, ov.b, s.b, s.b, s.t, s.t};
			return 1'b1;
		end
		if (tl && tt) begin
			xs = '{s.r, s.l, s.l, ov.r, ov.r, s.r};
			ys = '{s.b, s.b, ov.b, ov.b, s.t, s.t};
			return 1'b1;
		end
		if (tl && tb) begin
			xs = '{s.r, ov.r, ov.r, s.l, s.l, s.r};
			ys = '{s.b, s.b, ov.t, ov.t, s.t, s.t};
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic add_path(bit p, path6_t xs, path6_t ys, int n);
		vertex_t v;
		for (int i = 0; i < n; i++) begin
			v = '0;
			v.handled = 1'b1;
			v.path = p;
			v.x = coord_t'(xs[i]);
			v.y = coord_t'(ys[i]);
			v.path_end = (i == n - 1);
			outline_q.insert(outline_q.size(), v);
		end
	endtask

	task automatic add_box(bit p, box_t q);
		path6_t xs, ys;
		xs = '{q.r, q.l, q.l, q.r, 0, 0};
		ys = '{q.b, q.b, q.t, q.t, 0, 0};
		add_path(p, xs, ys, 4);
	endtask

	// expected vertices of the xor outline for one accepted pair
	task automatic predict_outline(pair_t p);
		box_t s, c, m, u, lo, hi;
		path6_t ax, ay, bx, by;
		area_t lhs, rhs;
		vertex_t v;
		bit refuse;
		refuse = 1'b0;
		outline_q.delete();
		s = '{longint'(p.sl), longint'(p.st), longint'(p.sr), longint'(p.sb)};
		c = '{longint'(p.cl), longint'(p.ct), longint'(p.cr), longint'(p.cb)};
		m = meet_of(s, c);
		if (!is_proper(m)) begin
			u.l = lmin(s.l, c.l);
			u.t = lmin(s.t, c.t);
			u.r = lmax(s.r, c.r);
			u.b = lmax(s.b, c.b);
			lhs = box_area(s) + box_area(c);
			rhs = box_area(u) + box_area(m);
			if (lhs == rhs) begin
				if (s.t == c.t && s.b == c.b && (s.r == c.l || c.r == s.l)) begin
					// side by side: lo is the left box, hi the right one
					lo = (s.l < c.l) ? s : c;
					hi = (s.l < c.l) ? c : s;
					ax = '{hi.l, u.r, u.r, hi.l, lo.l, lo.l};
					ay = '{u.t, u.t, u.b, u.b, u.b, u.t};
					add_path(1'b0, ax, ay, 6);
				end else if (s.l == c.l && s.r == c.r && (s.b == c.t || c.b == s.t)) begin
					// stacked: lo is the upper box, hi the lower one
					lo = (s.t < c.t) ? s : c;
					hi = (s.t < c.t) ? c : s;
					ax = '{u.r, u.l, u.l, u.l, u.r, u.r};
					ay = '{u.b, u.b, hi.t, lo.t, lo.t, hi.t};
					add_path(1'b0, ax, ay, 6);
				end else begin
					add_box(1'b0, u);
				end
			end else if (shares_side(s, c)) begin
				refuse = 1'b1;
			end else begin
				add_box(1'b0, s);
				add_box(1'b1, c);
			end
		end else if (corner_cut(s, c, ax, ay) && corner_cut(c, s, bx, by)) begin
			add_path(1'b0, ax, ay, 6);
			add_path(1'b1, bx, by, 6);
		end else begin
			refuse = 1'b1;
		end
		if (refuse) begin
			v = '0;
			v.last = 1'b1;
			expected_vertices.insert(expected_vertices.size(), v);
		end else begin
			for (int i = 0; i < outline_q.size(); i++) begin
				v = outline_q[i];
				v.last = (i == outline_q.size() - 1);
				expected_vertices.insert(expected_vertices.size(), v);
			end
		end
	endtask

	// stimulus helpers
	task automatic add_pair(coord_t a, coord_t b, coord_t c, coord_t d,
			coord_t e, coord_t f, coord_t g, coord_t h);
		pair_t p;
		p = '{a, b, c, d, e, f, g, h};
		pair_q.insert(pair_q.size(), p);
	endtask

	// four ascending coordinates: small, extreme or full range
	function automatic void pick_axis(output axis4_t v);
		coord_t tmp;
		case ($urandom_range(0, 4))
			0, 1: begin
				v[0] = coord_t'(int'($urandom_range(0, 60)) - 30);
				for (int i = 1; i < 4; i++) v[i] = v[i-1] + coord_t'($urandom_range(1, 5));
			end
			2: begin
				v[0] = CMIN;
				for (int i = 1; i < 4; i++) v[i] = v[i-1] + coord_t'($urandom_range(1, 9));
			end
			3: begin
				v[3] = CMAX;
				for (int i = 2; i >= 0; i--) v[i] = v[i+1] - coord_t'($urandom_range(1, 9));
			end
			default: begin
				for (int i = 0; i < 4; i++) v[i] = coord_t'($urandom);
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3 - i; j++) begin
						if (v[j] > v[j+1]) begin
							tmp = v[j];
							v[j] = v[j+1];
							v[j+1] = tmp;
						end
					end
				end
			end
		endcase
	endfunction

	// random pair, mostly shaped so that each outline branch is reached
	function automatic pair_t random_pair();
		axis4_t x, y;
		pair_t p, q;
		pick_axis(x);
		pick_axis(y);
		case ($urandom_range(0, 9))
			0, 1: p = '{x[0], y[0], x[1], y[1], x[1], y[0], x[2], y[1]};
			2, 3: begin
				if ($urandom_range(0, 1))
					p = '{x[0], y[0], x[2], y[2], x[1], y[1], x[3], y[3]};
				else
					p = '{x[0], y[1], x[2], y[3], x[1], y[0], x[3], y[2]};
			end
			4: begin
				if ($urandom_range(0, 1))
					p = '{x[0], y[0], x[1], y[1], x[2], y[2], x[3], y[3]};
				else
					p = '{x[0], y[0], x[1], y[1], x[2], y[0], x[3], y[1]};
			end
			5: p = '{x[0], y[0], x[1], y[2], x[1], y[1], x[2], y[3]};
			6: p = '{x[0], y[0], x[3], y[3], x[1], y[1], x[2], y[$urandom_range(2, 3)]};
			7: p = '{x[0], y[0], x[3], y[3],
					x[$urandom_range(0, 3)], y[$urandom_range(0, 3)],
					x[$urandom_range(0, 3)], y[$urandom_range(0, 3)]};
			8: p = '{x[$urandom_range(0, 3)], y[$urandom_range(0, 3)],
					x[$urandom_range(0, 3)], y[$urandom_range(0, 3)],
					x[$urandom_range(0, 3)], y[$urandom_range(0, 3)],
					x[$urandom_range(0, 3)], y[$urandom_range(0, 3)]};
			default: p = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), coord_t'($urandom)};
		endcase
		// swap x and y axes
		if ($urandom_range(0, 1))
			p = '{p.st, p.sl, p.sb, p.sr, p.ct, p.cl, p.cb, p.cr};
		// swap subject and clip
		if ($urandom_range(0, 1)) begin
			q = p;
			p = '{q.cl, q.ct, q.cr, q.cb, q.sl, q.st, q.sr, q.sb};
		end
		return p;
	endfunction

	// driver: launches pending pairs, predicts each transaction it hands over
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				predict_outline(drv);
				pairs_taken++;
				if (steady_left > 0) begin
					steady_left--;
					gap_left = 0;
				end else begin
					gap_left = $urandom_range(0, 18);
					if ($urandom_range(0, 15) == 0) steady_left = $urandom_range(10, 30);
				end
			end
			if (!start || taken) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pair_q.size() > 0) begin
					drv <= pair_q.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: each strobed vertex against the oldest expectation
	always @(posedge clk) begin
		vertex_t got, want;
		if (arst_n && result_valid) begin
			got = '{handled, path_index, vertex_x, vertex_y, path_end, last};
			vertices_seen++;
			if (!handled) refusals++;
			if (handled && path_index && last) two_path_outlines++;
			if (expected_vertices.size() == 0) begin
				$display("%0t: unexpected vertex h=%0b p=%0b x=%0d y=%0d end=%0b last=%0b",
					$time, got.handled, got.path, got.x, got.y, got.path_end, got.last);
				mismatches++;
			end else begin
				want = expected_vertices.pop_front();
				if (got !== want) begin
					$display("%0t: vertex mismatch, expected h=%0b p=%0b x=%0d y=%0d end=%0b last=%0b",
						$time, want.handled, want.path, want.x, want.y, want.path_end, want.last);
					$display("%0t:                  actual h=%0b p=%0b x=%0d y=%0d end=%0b last=%0b",
						$time, got.handled, got.path, got.x, got.y, got.path_end, got.last);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("Test completed with failures");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		// directed pairs: every outline shape, refusals, degenerate and extreme edges
		add_pair(0, 0, 0, 0, 0, 0, 0, 0);
		add_pair(0, 0, 4, 3, 4, 0, 9, 3);
		add_pair(4, 0, 9, 3, 0, 0, 4, 3);
		add_pair(0, 0, 5, 2, 0, 2, 5, 7);
		add_pair(0, 2, 5, 7, 0, 0, 5, 2);
		add_pair(0, 0, 2, 2, 5, 5, 8, 9);
		add_pair(0, 0, 4, 4, 4, 2, 8, 6);
		add_pair(0, 0, 4, 4, 2, 4, 6, 8);
		add_pair(0, 0, 6, 6, 3, 3, 9, 9);
		add_pair(3, 3, 9, 9, 0, 0, 6, 6);
		add_pair(0, 3, 6, 9, 3, 0, 9, 6);
		add_pair(3, 0, 9, 6, 0, 3, 6, 9);
		add_pair(0, 0, 10, 10, 2, 2, 5, 5);
		add_pair(1, 1, 5, 5, 1, 1, 5, 5);
		add_pair(0, 0, 10, 4, 3, 2, 6, 8);
		add_pair(0, 0, 10, 10, 3, 3, 3, 7);
		add_pair(5, 5, 1, 1, 2, 2, 8, 8);
		add_pair(0, 0, 2, 2, 2, 2, 4, 4);
		add_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX);
		add_pair(CMIN, CMIN, 0, CMAX, 0, CMIN, CMAX, CMAX);
		add_pair(CMIN, CMIN, CMAX, 0, CMIN, 0, CMAX, CMAX);
		add_pair(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX);
		add_pair(CMIN, CMIN, 1, 1, 0, 0, CMAX, CMAX);
		add_pair(-1, -1, -1, -1, -1, -1, -1, -1);
		add_pair(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
		for (int i = 0; i < RANDOM_PAIRS; i++) pair_q.insert(pair_q.size(), random_pair());

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// drain: every pair handed over and every vertex seen
		do @(posedge clk);
		while (pair_q.size() != 0 || start || expected_vertices.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d rectangle pairs and %0d vertices", pairs_taken, vertices_seen);
		$display("%0d pairs not handled, %0d two-path outlines", refusals, two_path_outlines);
		if (mismatches == 0 && expected_vertices.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/tro_pkg.sv
hw/rtl/tro_front.sv
hw/rtl/tro_queue.sv
hw/rtl/tro_back.sv
hw/rtl/two_rectangle_xor_outline.sv
hw/rtl/tro_checker.sv
sim/two_rectangle_xor_outline_test.sv
